// ===== design/text_mode_cell_pixel_generator_assert.svh =====
// Assertion macros for the text-mode cell pixel generator.
`ifndef TEXT_MODE_CELL_PIXEL_GENERATOR_ASSERT_SVH
`define TEXT_MODE_CELL_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMCPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMCPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tmcpg_pkg.sv =====
package tmcpg_pkg;

  // Display geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 24;
  localparam int CELL_LINES = 10;
  // Text memory depth, a power of two
  localparam int TEXT_DEPTH = 2048;

  localparam int TEXT_ADDR_W = $clog2(TEXT_DEPTH);
  // Wide enough for COLUMNS * row + start + column at every legal geometry
  localparam int SUM_W       = 16;

  localparam int SCAN_W = 8;
  localparam int LINE_W = 5;

  // Reciprocal for scan_line / CELL_LINES, exact over all 8-bit scan lines
  localparam int DIV_SHIFT = SCAN_W + $clog2(CELL_LINES);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + CELL_LINES - 1) / CELL_LINES;
  localparam int MULT_W    = DIV_SHIFT + 1;
  localparam int PROD_W    = SCAN_W + MULT_W;

  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_ADDRESS  = 3'd0,
    REG_CURSOR_ADDRESS = 3'd1,
    REG_CURSOR_FIRST   = 3'd2,
    REG_CURSOR_LAST    = 3'd3,
    REG_CURSOR_MODE    = 3'd4,
    REG_MONO_MODE      = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    CURSOR_STEADY     = 2'd0,
    CURSOR_OFF        = 2'd1,
    CURSOR_BLINK_FAST = 2'd2,
    CURSOR_BLINK_SLOW = 2'd3
  } cursor_mode_t;

  // Colour codes
  localparam logic [3:0] COLOUR_WHITE = 4'd7;
  localparam logic [3:0] MONO_LEVEL0  = 4'd8;
  localparam logic [3:0] MONO_LEVEL1  = 4'd9;
  localparam logic [3:0] MONO_LEVEL2  = 4'd10;
  localparam logic [3:0] MONO_LEVEL3  = 4'd11;

  typedef struct packed {
    logic [7:0] scan_line;
    logic [5:0] frame_count;
    logic [6:0] column;
    logic [7:0] attribute;
    logic [7:0] alpha_row_bits;
    logic [7:0] graphic_row_bits;
  } cell_t;

  typedef struct packed {
    logic [10:0] text_address;
    logic [7:0]  pixel_bits;
    logic [3:0]  fg_code;
    logic [3:0]  bg_code;
    logic        frame_done;
  } pix_t;

  typedef struct packed {
    logic [13:0]      start_address;
    logic [13:0]      cursor_address;
    logic [LINE_W-1:0] cursor_first_line;
    logic [LINE_W-1:0] cursor_last_line;
    cursor_mode_t     cursor_mode;
    logic             mono_mode;
  } cfg_t;

endpackage

// ===== design/tmcpg_row_split.sv =====
module tmcpg_row_split (
  input  logic [tmcpg_pkg::SCAN_W-1:0] scan_line,
  output logic [tmcpg_pkg::SCAN_W-1:0] row
);

  localparam int MW = tmcpg_pkg::MULT_W;
  localparam int PW = tmcpg_pkg::PROD_W;

  logic [PW-1:0] prod;

  // Multiply by the reciprocal and drop the fraction
  assign prod = PW'(scan_line) * PW'(MW'(tmcpg_pkg::DIV_MULT));
  assign row  = tmcpg_pkg::SCAN_W'(prod >> tmcpg_pkg::DIV_SHIFT);

endmodule

// ===== design/tmcpg_cell_logic.sv =====
module tmcpg_cell_logic (
  input  tmcpg_pkg::cell_t              cell_word,
  input  logic [tmcpg_pkg::SCAN_W-1:0]  row,
  input  tmcpg_pkg::cfg_t               cfg,
  output tmcpg_pkg::pix_t               pix
);

  localparam int AW = tmcpg_pkg::TEXT_ADDR_W;
  localparam int SW = tmcpg_pkg::SUM_W;
  localparam int LW = tmcpg_pkg::LINE_W;

  logic [SW-1:0]                 row_base;
  logic [SW-1:0]                 addr_sum;
  logic [AW-1:0]                 addr;
  logic [AW-1:0]                 csr_addr;
  logic [tmcpg_pkg::SCAN_W-1:0]  line_base;
  logic [tmcpg_pkg::SCAN_W-1:0]  line_diff;
  logic [LW-1:0]                 line;
  logic                          in_window;
  logic                          csr_on;
  logic [3:0]                    fg;
  logic [3:0]                    bg;
  logic [3:0]                    fg_swap;
  logic [3:0]                    bg_swap;

  assign row_base = SW'(row) * SW'(tmcpg_pkg::COLUMNS);
  assign addr_sum = row_base + SW'(cfg.start_address) + SW'(cell_word.column);
  assign addr     = addr_sum[AW-1:0];
  assign csr_addr = cfg.cursor_address[AW-1:0];

  assign line_base = tmcpg_pkg::SCAN_W'(SW'(row) * SW'(tmcpg_pkg::CELL_LINES));
  assign line_diff = cell_word.scan_line - line_base;
  assign line      = line_diff[LW-1:0];

  assign in_window = (line >= cfg.cursor_first_line) && (line <= cfg.cursor_last_line);

  always_comb begin
    csr_on = 1'b0;
    unique case (cfg.cursor_mode)
      tmcpg_pkg::CURSOR_STEADY:     csr_on = 1'b1;
      tmcpg_pkg::CURSOR_OFF:        csr_on = 1'b0;
      tmcpg_pkg::CURSOR_BLINK_FAST: csr_on = cell_word.frame_count[4];
      tmcpg_pkg::CURSOR_BLINK_SLOW: csr_on = cell_word.frame_count[5];
      default:                      csr_on = 1'b0;
    endcase
  end

  always_comb begin
    if (cfg.mono_mode) begin
      fg_swap = cell_word.attribute[2] ? tmcpg_pkg::MONO_LEVEL3 : tmcpg_pkg::MONO_LEVEL2;
      bg_swap = cell_word.attribute[5] ? tmcpg_pkg::MONO_LEVEL1 : tmcpg_pkg::MONO_LEVEL0;
      // inverse video
      if (cell_word.attribute[0]) begin
        fg = bg_swap;
        bg = fg_swap;
      end else begin
        fg = fg_swap;
        bg = bg_swap;
      end
    end else begin
      fg_swap = 4'(cell_word.attribute[2:0]);
      bg_swap = 4'(cell_word.attribute[5:3]);
      fg      = fg_swap;
      bg      = bg_swap;
    end
  end

  always_comb begin
    pix.text_address = 11'(addr);
    pix.pixel_bits   = cell_word.attribute[7] ? cell_word.graphic_row_bits
                                              : cell_word.alpha_row_bits;
    pix.fg_code      = fg;
    pix.bg_code      = bg;
    // attribute blink swaps the pair
    if (cell_word.frame_count[5] && cell_word.attribute[6]) begin
      pix.fg_code = bg;
      pix.bg_code = fg;
    end
    // cursor forces white, glyph row still shown
    if (in_window && csr_on && (addr == csr_addr)) begin
      pix.fg_code = tmcpg_pkg::COLOUR_WHITE;
      pix.bg_code = tmcpg_pkg::COLOUR_WHITE;
    end
    pix.frame_done = (12'(cell_word.scan_line) ==
                      12'(tmcpg_pkg::ROWS * tmcpg_pkg::CELL_LINES - 1)) &&
                     (8'(cell_word.column) == 8'(tmcpg_pkg::COLUMNS - 1));
  end

endmodule

// ===== design/text_mode_cell_pixel_generator.sv =====
// Text-mode cell pixel generator. Takes one character cell per word on the
// cell channel (scan line, frame count, column, attribute byte and both
// character-generator rows) and returns one pixel word per cell: the
// wrapped text-memory address, eight pixel bits, foreground and background
// codes and a frame-done flag on the last cell of the last scan line.
// A cell word taken into the input register goes on to the output
// register as its pixel word; a new cell word is taken every cycle while
// the pixel side keeps up. The input and output registers are the only
// stages, with the cell row taken from the scan line by a reciprocal
// multiply ahead of the input register. Configuration registers (start
// address, cursor address, cursor lines, cursor mode, mono mode) are
// written through cfg_write/cfg_index/cfg_data and should change only
// while no cell is in flight. Configuration registers and valid flags
// clear on reset; the payload registers are loaded only with valid words.
module text_mode_cell_pixel_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_write,
  input  logic [tmcpg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tmcpg_pkg::CFG_DATA_W-1:0]      cfg_data,
  // cell words in
  input  logic                                  cell_valid,
  output logic                                  cell_stall,
  input  tmcpg_pkg::cell_t                      cell_word,
  // pixel words out
  output logic                                  pix_valid,
  input  logic                                  pix_stall,
  output tmcpg_pkg::pix_t                       pix
);

  `include "text_mode_cell_pixel_generator_assert.svh"

  tmcpg_pkg::cfg_t                      cfg;
  tmcpg_pkg::cell_t                     s1_cell;
  logic [tmcpg_pkg::SCAN_W-1:0]         s1_row;
  logic                                 s1_valid;
  logic [tmcpg_pkg::SCAN_W-1:0]         row_next;
  tmcpg_pkg::pix_t                      pix_next;
  logic                                 out_adv;
  logic                                 s1_adv;

  // Configuration registers: masked to width, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_address     <= '0;
      cfg.cursor_address    <= '0;
      cfg.cursor_first_line <= '0;
      cfg.cursor_last_line  <= '0;
      cfg.cursor_mode       <= tmcpg_pkg::CURSOR_STEADY;
      cfg.mono_mode         <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tmcpg_pkg::REG_START_ADDRESS:  cfg.start_address  <= cfg_data[13:0];
        tmcpg_pkg::REG_CURSOR_ADDRESS: cfg.cursor_address <= cfg_data[13:0];
        tmcpg_pkg::REG_CURSOR_FIRST:
          cfg.cursor_first_line <= cfg_data[tmcpg_pkg::LINE_W-1:0];
        tmcpg_pkg::REG_CURSOR_LAST:
          cfg.cursor_last_line <= cfg_data[tmcpg_pkg::LINE_W-1:0];
        tmcpg_pkg::REG_CURSOR_MODE:
          cfg.cursor_mode <= tmcpg_pkg::cursor_mode_t'(cfg_data[1:0]);
        tmcpg_pkg::REG_MONO_MODE:      cfg.mono_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Split the scan line into cell row ahead of the input register
  tmcpg_row_split u_row_split (
    .scan_line (cell_word.scan_line),
    .row       (row_next)
  );

  // Address, cursor and colour logic between the two registers
  tmcpg_cell_logic u_cell_logic (
    .cell_word (s1_cell),
    .row       (s1_row),
    .cfg       (cfg),
    .pix       (pix_next)
  );

  // Advance each stage when the one after it has room
  assign out_adv    = !pix_valid || !pix_stall;
  assign s1_adv     = !s1_valid || out_adv;
  assign cell_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= cell_valid;
      end
      if (out_adv) begin
        pix_valid <= s1_valid;
      end
    end
  end

  // Payload: load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (s1_adv && cell_valid) begin
      s1_cell <= cell_word;
      s1_row  <= row_next;
    end
    if (out_adv && s1_valid) begin
      pix <= pix_next;
    end
  end

  // A stall toward the cell side means both stages are full and blocked
  `TMCPG_ASSERT_NOW(a_stall_full, clk, rst, cell_stall, s1_valid && pix_valid && pix_stall, "cell stall without full pipeline")
  // A held cell moves into the output register when it advances
  `TMCPG_ASSERT_NEXT(a_s1_moves, clk, rst, s1_valid && out_adv, pix_valid, "cell word lost between stages")
  // Colour codes stay within the palette and mono levels
  `TMCPG_ASSERT_NOW(a_code_range, clk, rst, pix_valid, (pix.fg_code <= tmcpg_pkg::MONO_LEVEL3) && (pix.bg_code <= tmcpg_pkg::MONO_LEVEL3), "colour code out of range")

endmodule

// ===== tb/text_mode_cell_pixel_generator_tb.sv =====
`timescale 1ns / 100ps

module text_mode_cell_pixel_generator_tb;

  // Indexes past the register file; writes to them must change nothing
  localparam logic [tmcpg_pkg::CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [tmcpg_pkg::CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int IDLE_PERCENT    = 31;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 4;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [tmcpg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tmcpg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                              cell_valid = 1'b0;
  logic                              cell_stall;
  tmcpg_pkg::cell_t                  cell_word = '0;
  logic                              pix_valid;
  logic                              pix_stall = 1'b0;
  tmcpg_pkg::pix_t                   pix;

  // Register image the predictor works from; written only while idle
  tmcpg_pkg::cfg_t shadow_cfg = '0;

  tmcpg_pkg::cell_t cells_to_send[$];
  tmcpg_pkg::pix_t  pixel_words_due[$];
  int    cells_queued = 0;
  int    cells_sent = 0;
  int    mismatch_count = 0;

  // Accepted-last-edge flag for the driver, sampled at the rising edge
  logic cell_took = 1'b0;

  // Idle control: no_idle turns off random gaps on both sides;
  // bumping hold_req makes the receiver hold off for a long stretch
  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  text_mode_cell_pixel_generator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_word  (cell_word),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix        (pix)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Work out the pixel word for one cell from the current register image.
  function automatic tmcpg_pkg::pix_t predict_pixels(tmcpg_pkg::cell_t c);
    tmcpg_pkg::pix_t p;
    int unsigned     cell_row;
    int unsigned     cell_line;
    int unsigned     addr;
    logic            cursor_lit;
    logic [3:0]      fg;
    logic [3:0]      bg;
    logic [3:0]      held;
    cell_row  = c.scan_line / tmcpg_pkg::CELL_LINES;
    cell_line = c.scan_line % tmcpg_pkg::CELL_LINES;
    addr = (tmcpg_pkg::COLUMNS * cell_row + shadow_cfg.start_address + c.column) %
           tmcpg_pkg::TEXT_DEPTH;

    // Cursor shows only inside the line window; an inverted window shows nothing
    cursor_lit = 1'b0;
    if (cell_line >= shadow_cfg.cursor_first_line &&
        cell_line <= shadow_cfg.cursor_last_line) begin
      case (shadow_cfg.cursor_mode)
        tmcpg_pkg::CURSOR_STEADY:     cursor_lit = 1'b1;
        tmcpg_pkg::CURSOR_OFF:        cursor_lit = 1'b0;
        tmcpg_pkg::CURSOR_BLINK_FAST: cursor_lit = c.frame_count[4];
        default:                      cursor_lit = c.frame_count[5];
      endcase
    end

    if (shadow_cfg.mono_mode) begin
      fg = c.attribute[2] ? tmcpg_pkg::MONO_LEVEL3 : tmcpg_pkg::MONO_LEVEL2;
      bg = c.attribute[5] ? tmcpg_pkg::MONO_LEVEL1 : tmcpg_pkg::MONO_LEVEL0;
      // Mono inverse swaps before the attribute blink does
      if (c.attribute[0]) begin
        held = fg;
        fg = bg;
        bg = held;
      end
    end else begin
      fg = {1'b0, c.attribute[2:0]};
      bg = {1'b0, c.attribute[5:3]};
    end
    if (c.frame_count[5] && c.attribute[6]) begin
      held = fg;
      fg = bg;
      bg = held;
    end
    // Cursor forces white on both codes, in mono mode too
    if (cursor_lit && addr == shadow_cfg.cursor_address % tmcpg_pkg::TEXT_DEPTH) begin
      fg = tmcpg_pkg::COLOUR_WHITE;
      bg = tmcpg_pkg::COLOUR_WHITE;
    end

    p.text_address = addr[tmcpg_pkg::TEXT_ADDR_W-1:0];
    p.pixel_bits   = c.attribute[7] ? c.graphic_row_bits : c.alpha_row_bits;
    p.fg_code      = fg;
    p.bg_code      = bg;
    p.frame_done   = (c.scan_line == tmcpg_pkg::ROWS * tmcpg_pkg::CELL_LINES - 1) &&
                     (c.column == tmcpg_pkg::COLUMNS - 1);
    return p;
  endfunction

  task automatic log_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Driver: present the next cell word at the falling edge once the current
  // one is taken; hold the payload steady while the block stalls.
  always @(negedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (!cell_valid || cell_took) begin
      if (cells_to_send.size() > 0 &&
          (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
        cell_word  <= cells_to_send.pop_front();
        cell_valid <= 1'b1;
      end else begin
        cell_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: a requested hold-off wins, otherwise stall at random.
  always @(negedge clk) begin
    if (rst) begin
      pix_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_OFF_CYCLES;
      pix_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pix_stall <= 1'b1;
    end else begin
      pix_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Monitor: check each pixel word against the oldest prediction, then
  // record the cell word taken at this edge. A cell cannot come out on the
  // edge that takes it, so the order of the two steps is safe.
  always @(posedge clk) begin
    tmcpg_pkg::pix_t want;
    cell_took <= !rst && cell_valid && !cell_stall;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        if (pixel_words_due.size() == 0) begin
          log_mismatch($sformatf("pixel word with none due: %h", pix));
        end else begin
          want = pixel_words_due.pop_front();
          if (pix.text_address !== want.text_address)
            log_mismatch($sformatf("text_address %0d, want %0d",
                                   pix.text_address, want.text_address));
          if (pix.pixel_bits !== want.pixel_bits)
            log_mismatch($sformatf("pixel_bits %h, want %h", pix.pixel_bits, want.pixel_bits));
          if (pix.fg_code !== want.fg_code)
            log_mismatch($sformatf("fg_code %0d, want %0d", pix.fg_code, want.fg_code));
          if (pix.bg_code !== want.bg_code)
            log_mismatch($sformatf("bg_code %0d, want %0d", pix.bg_code, want.bg_code));
          if (pix.frame_done !== want.frame_done)
            log_mismatch($sformatf("frame_done %b, want %b", pix.frame_done, want.frame_done));
        end
      end
      if (cell_valid && !cell_stall) begin
        pixel_words_due.push_back(predict_pixels(cell_word));
        cells_sent++;
      end
    end
  end

  // Write one register at the falling edge and mirror it in the image.
  task automatic write_reg(logic [tmcpg_pkg::CFG_INDEX_W-1:0] index,
                           logic [tmcpg_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      tmcpg_pkg::REG_START_ADDRESS:  shadow_cfg.start_address = value;
      tmcpg_pkg::REG_CURSOR_ADDRESS: shadow_cfg.cursor_address = value;
      tmcpg_pkg::REG_CURSOR_FIRST:
        shadow_cfg.cursor_first_line = value[tmcpg_pkg::LINE_W-1:0];
      tmcpg_pkg::REG_CURSOR_LAST:
        shadow_cfg.cursor_last_line = value[tmcpg_pkg::LINE_W-1:0];
      tmcpg_pkg::REG_CURSOR_MODE:
        shadow_cfg.cursor_mode = tmcpg_pkg::cursor_mode_t'(value[1:0]);
      tmcpg_pkg::REG_MONO_MODE:      shadow_cfg.mono_mode = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_cell(logic [7:0] scan, logic [5:0] frame, logic [6:0] col,
                            logic [7:0] attr, logic [7:0] alpha, logic [7:0] graphic);
    tmcpg_pkg::cell_t c;
    c.scan_line        = scan;
    c.frame_count      = frame;
    c.column           = col;
    c.attribute        = attr;
    c.alpha_row_bits   = alpha;
    c.graphic_row_bits = graphic;
    cells_to_send.push_back(c);
    cells_queued++;
  endtask

  // Random cells over the full field ranges; about a third are steered onto
  // the cursor address and a few onto the last cell of the frame.
  task automatic queue_random_cells(int count);
    tmcpg_pkg::cell_t c;
    int    pick;
    int    r;
    int    offset;
    int    tries;
    repeat (count) begin
      c.scan_line        = 8'($urandom_range(255));
      c.frame_count      = 6'($urandom_range(63));
      c.column           = 7'($urandom_range(127));
      c.attribute        = 8'($urandom_range(255));
      c.alpha_row_bits   = 8'($urandom_range(255));
      c.graphic_row_bits = 8'($urandom_range(255));
      pick = int'($urandom_range(99));
      if (pick < 30) begin
        for (tries = 0; tries < 64; tries++) begin
          r = int'($urandom_range(25));
          offset = int'(shadow_cfg.cursor_address) - int'(shadow_cfg.start_address) -
                   tmcpg_pkg::COLUMNS * r;
          offset = ((offset % tmcpg_pkg::TEXT_DEPTH) + tmcpg_pkg::TEXT_DEPTH) %
                   tmcpg_pkg::TEXT_DEPTH;
          if (offset < 128) begin
            c.column    = 7'(offset);
            c.scan_line = 8'(r * tmcpg_pkg::CELL_LINES +
                             int'($urandom_range(r == 25 ? 5 : 9)));
            break;
          end
        end
      end else if (pick < 35) begin
        c.scan_line = 8'(tmcpg_pkg::ROWS * tmcpg_pkg::CELL_LINES - 1);
        c.column    = 7'(tmcpg_pkg::COLUMNS - 1);
      end
      cells_to_send.push_back(c);
      cells_queued++;
    end
  endtask

  // Hold until every queued cell is taken and every pixel word is back,
  // then let the pipeline settle.
  task automatic wait_for_pixels();
    int waited;
    waited = 0;
    while ((cells_sent != cells_queued || pixel_words_due.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT)
      log_mismatch($sformatf("%0d pixel words never arrived", pixel_words_due.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers: cursor steady on line 0 at address 0
    queue_cell(8'd0,   6'h00, 7'd0,   8'h07, 8'hA5, 8'h5A);
    queue_cell(8'd239, 6'h00, 7'd79,  8'h80, 8'h00, 8'hFF);
    queue_cell(8'd255, 6'h3F, 7'd127, 8'hFF, 8'hFF, 8'h00);
    queue_cell(8'd0,   6'h20, 7'd1,   8'h4A, 8'h3C, 8'hC3);
    queue_cell(8'd10,  6'h1F, 7'd0,   8'h38, 8'h81, 8'h7E);
    queue_cell(8'd238, 6'h00, 7'd79,  8'h00, 8'h01, 8'h80);
    queue_cell(8'd239, 6'h00, 7'd78,  8'h00, 8'h01, 8'h80);
    queue_random_cells(150);
    wait_for_pixels();

    // Mono, top of every address range, full cursor window
    write_reg(tmcpg_pkg::REG_START_ADDRESS, 14'h3FFF);
    write_reg(tmcpg_pkg::REG_CURSOR_ADDRESS, 14'h3FFF);
    write_reg(tmcpg_pkg::REG_CURSOR_FIRST, 14'd0);
    write_reg(tmcpg_pkg::REG_CURSOR_LAST, 14'd31);
    write_reg(tmcpg_pkg::REG_CURSOR_MODE, 14'(tmcpg_pkg::CURSOR_STEADY));
    write_reg(tmcpg_pkg::REG_MONO_MODE, 14'd1);
    queue_cell(8'd0, 6'h00, 7'd0, 8'h25, 8'hF0, 8'h0F);
    queue_cell(8'd0, 6'h00, 7'd1, 8'h01, 8'hF0, 8'h0F);
    queue_cell(8'd5, 6'h3F, 7'd1, 8'h65, 8'h55, 8'hAA);
    queue_cell(8'd9, 6'h00, 7'd0, 8'h24, 8'h55, 8'hAA);
    queue_random_cells(210);
    wait_for_pixels();

    // Fast blink in lines 2..7; receiver holds off while the sender pushes on
    write_reg(tmcpg_pkg::REG_START_ADDRESS, 14'd1234);
    write_reg(tmcpg_pkg::REG_CURSOR_ADDRESS, 14'd555);
    write_reg(tmcpg_pkg::REG_CURSOR_FIRST, 14'd2);
    write_reg(tmcpg_pkg::REG_CURSOR_LAST, 14'd7);
    write_reg(tmcpg_pkg::REG_CURSOR_MODE, 14'(tmcpg_pkg::CURSOR_BLINK_FAST));
    write_reg(tmcpg_pkg::REG_MONO_MODE, 14'd0);
    queue_cell(8'd172, 6'h10, 7'd9, 8'h12, 8'h99, 8'h66);
    queue_cell(8'd172, 6'h00, 7'd9, 8'h12, 8'h99, 8'h66);
    queue_cell(8'd172, 6'h20, 7'd9, 8'h12, 8'h99, 8'h66);
    queue_cell(8'd178, 6'h10, 7'd9, 8'h12, 8'h99, 8'h66);
    queue_random_cells(210);
    @(posedge clk);
    hold_req++;
    wait_for_pixels();

    // Slow blink on the last cell line only, mono; no gaps on either side
    write_reg(tmcpg_pkg::REG_START_ADDRESS, 14'd0);
    write_reg(tmcpg_pkg::REG_CURSOR_ADDRESS, 14'h2000);
    write_reg(tmcpg_pkg::REG_CURSOR_FIRST, 14'd9);
    write_reg(tmcpg_pkg::REG_CURSOR_LAST, 14'd9);
    write_reg(tmcpg_pkg::REG_CURSOR_MODE, 14'(tmcpg_pkg::CURSOR_BLINK_SLOW));
    write_reg(tmcpg_pkg::REG_MONO_MODE, 14'd1);
    @(posedge clk);
    no_idle = 1'b1;
    queue_cell(8'd9, 6'h20, 7'd0, 8'hC0, 8'h18, 8'h24);
    queue_cell(8'd9, 6'h10, 7'd0, 8'hC0, 8'h18, 8'h24);
    queue_random_cells(210);
    wait_for_pixels();
    no_idle = 1'b0;

    // Inverted window: first line below last shows no cursor
    write_reg(tmcpg_pkg::REG_START_ADDRESS, 14'd100);
    write_reg(tmcpg_pkg::REG_CURSOR_ADDRESS, 14'd900);
    write_reg(tmcpg_pkg::REG_CURSOR_FIRST, 14'd6);
    write_reg(tmcpg_pkg::REG_CURSOR_LAST, 14'd3);
    write_reg(tmcpg_pkg::REG_CURSOR_MODE, 14'(tmcpg_pkg::CURSOR_STEADY));
    write_reg(tmcpg_pkg::REG_MONO_MODE, 14'd0);
    queue_cell(8'd103, 6'h00, 7'd0, 8'h3F, 8'h42, 8'h24);
    queue_cell(8'd106, 6'h00, 7'd0, 8'h3F, 8'h42, 8'h24);
    queue_random_cells(210);
    wait_for_pixels();

    // Cursor off; oversized data gets masked, spare indexes get dropped
    write_reg(tmcpg_pkg::REG_START_ADDRESS, 14'h0800);
    write_reg(tmcpg_pkg::REG_CURSOR_ADDRESS, 14'h07FF);
    write_reg(tmcpg_pkg::REG_CURSOR_FIRST, 14'h3FE0);
    write_reg(tmcpg_pkg::REG_CURSOR_LAST, 14'd0);
    write_reg(tmcpg_pkg::REG_CURSOR_MODE, 14'h3FFD);
    write_reg(tmcpg_pkg::REG_MONO_MODE, 14'h3FFF);
    write_reg(REG_SPARE_6, 14'h3FFF);
    write_reg(REG_SPARE_7, 14'h1555);
    queue_cell(8'd250, 6'h3F, 7'd47, 8'h05, 8'hE7, 8'h7E);
    queue_random_cells(210);
    wait_for_pixels();

    // Random register values throughout
    write_reg(tmcpg_pkg::REG_START_ADDRESS, 14'($urandom_range(16383)));
    write_reg(tmcpg_pkg::REG_CURSOR_ADDRESS, 14'($urandom_range(16383)));
    write_reg(tmcpg_pkg::REG_CURSOR_FIRST, 14'($urandom_range(16383)));
    write_reg(tmcpg_pkg::REG_CURSOR_LAST, 14'($urandom_range(16383)));
    write_reg(tmcpg_pkg::REG_CURSOR_MODE, 14'($urandom_range(16383)));
    write_reg(tmcpg_pkg::REG_MONO_MODE, 14'($urandom_range(16383)));
    queue_random_cells(210);
    wait_for_pixels();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tmcpg_pkg.sv
design/tmcpg_row_split.sv
design/tmcpg_cell_logic.sv
design/text_mode_cell_pixel_generator.sv
tb/text_mode_cell_pixel_generator_tb.sv
